/* hw/rtl/rwz_pkg.sv */
// Shared types and constants for the rolling window z-normalisation block.
// No dependencies; used by the top level, controller, datapath and checker by scoped names.
`default_nettype none

package rwz_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKFILL = 2'd1;
  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 7'd16;

  // result fields
  localparam int ZS_W     = 16;
  localparam int MEAN_W   = 24;
  localparam int SD_OUT_W = 23;
  localparam int M_DATA_W = 64;
  localparam int M_USER_W = 2;

  localparam logic signed [63:0] MEAN_MAX = 64'sd8388607;
  localparam logic signed [63:0] MEAN_MIN = -64'sd8388608;
  localparam logic [63:0] SD_MAX = 64'd8388607;
  localparam logic [63:0] Z_POS_MAX = 64'd32767;
  localparam logic [63:0] Z_NEG_MAX = 64'd32768;
  localparam logic [ZS_W-1:0] Z_SAT_POS = 16'h7fff;
  localparam logic [ZS_W-1:0] Z_SAT_NEG = 16'h8000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_MUL,
    ST_NUM,
    ST_MDIV,
    ST_VDIV,
    ST_SQRT,
    ST_ZDIV,
    ST_OUT,
    ST_BLANK
  } state_t;

  typedef struct packed {
    logic take;
    logic rd;
    logic upd;
    logic mul;
    logic div_mean;
    logic div_var;
    logic sqrt_go;
    logic div_z;
    logic load_res;
    logic load_blank;
  } cmd_t;

  typedef struct packed {
    logic filling;
    logic backfill;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/rolling_window_znorm.sv */
// Sliding-window z-normalisation, one sample in at a time.
// A full-window sample runs the bit-serial divider three times (mean,
// variance, z-score) and the root unit once; warm-up samples skip both.
// One sample in flight.
// Backfill emits the window length of result copies, one per cycle while m_tready is high.
// Reset (rst, synchronous): window 16, backfill off, window empty.
`default_nettype none

module rolling_window_znorm #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata, // sample
  input  logic s_tuser,                                     // new_series
  output logic m_tvalid,
  input  logic m_tready,
  output logic [rwz_pkg::M_DATA_W-1:0] m_tdata, // zscore, window_mean, window_stddev
  output logic [rwz_pkg::M_USER_W-1:0] m_tuser, // result_valid, zero_spread
  output logic m_tlast,                         // last_of_run
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [rwz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwz_pkg::CFG_DATA_W-1:0] cfg_data
);

  rwz_pkg::cmd_t cmd;
  rwz_pkg::sts_t sts;

  logic [rwz_pkg::ZS_W-1:0]     zscore;
  logic [rwz_pkg::MEAN_W-1:0]   window_mean;
  logic [rwz_pkg::SD_OUT_W-1:0] window_stddev;
  logic                         result_valid;
  logic                         zero_spread;

  assign cfg_ready = 1'b1;

  rwz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rwz_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample        ($signed(s_tdata[SAMPLE_BITS-1:0])),
    .new_series    (s_tuser),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .last_of_run   (m_tlast),
    .zscore        (zscore),
    .window_mean   (window_mean),
    .window_stddev (window_stddev),
    .result_valid  (result_valid),
    .zero_spread   (zero_spread)
  );

  assign m_tdata = {1'b0, window_stddev, window_mean, zscore};
  assign m_tuser = {zero_spread, result_valid};

endmodule

`default_nettype wire

/* hw/rtl/rwz_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Standalone; used by the datapath for the mean, variance and z-score.
`default_nettype none

module rwz_div #(
  parameter int N = 60,
  parameter int D = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     quo;
  logic [D-1:0]     rem;
  logic [D-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [D:0]       rem_sh;
  logic [D:0]       rem_sub;
  logic             ge;

  assign rem_sh  = {rem, quo[N-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[N-2:0], ge};
      rem <= ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rwz_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
// Standalone; used by the datapath for the standard deviation.
`default_nettype none

module rwz_sqrt #(
  parameter int RW = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CNT_W = $clog2(RW + 1);

  logic [2*RW-1:0]  v;
  logic [RW+1:0]    rem;
  logic [RW-1:0]    rt;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [RW+1:0]    rem_sh;
  logic [RW+1:0]    trial;
  logic             ge;

  assign rem_sh = {rem[RW-1:0], v[2*RW-1:2*RW-2]};
  assign trial  = {rt, 2'b01};
  assign ge     = rem_sh >= trial;
  assign root   = rt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v   <= radicand;
      rem <= '0;
      rt  <= '0;
    end else if (busy) begin
      v   <= {v[2*RW-3:0], 2'b00};
      rem <= ge ? rem_sh - trial : rem_sh;
      rt  <= RW'({rt, ge});
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rwz_ctrl.sv */
// Sequencing state machine: steps one sample through update and, once the window
// is full, the mean / variance / root / z-score stages. Depends on rwz_pkg.
`default_nettype none

module rwz_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  rwz_pkg::sts_t sts,
  output rwz_pkg::cmd_t cmd
);

  rwz_pkg::state_t state;
  rwz_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwz_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rwz_pkg::ST_IDLE:  if (s_tvalid) state_next = rwz_pkg::ST_READ;
      rwz_pkg::ST_READ:  state_next = rwz_pkg::ST_UPD;
      rwz_pkg::ST_UPD:   state_next = rwz_pkg::ST_MUL;
      rwz_pkg::ST_MUL: begin
        if (sts.filling) begin
          state_next = sts.backfill ? rwz_pkg::ST_IDLE : rwz_pkg::ST_BLANK;
        end else begin
          state_next = rwz_pkg::ST_NUM;
        end
      end
      rwz_pkg::ST_NUM:   state_next = rwz_pkg::ST_MDIV;
      rwz_pkg::ST_MDIV:  if (sts.div_done) state_next = rwz_pkg::ST_VDIV;
      rwz_pkg::ST_VDIV:  if (sts.div_done) state_next = rwz_pkg::ST_SQRT;
      rwz_pkg::ST_SQRT:  if (sts.sqrt_done) state_next = rwz_pkg::ST_ZDIV;
      rwz_pkg::ST_ZDIV:  if (sts.div_done) state_next = rwz_pkg::ST_OUT;
      rwz_pkg::ST_OUT:   if (sts.out_free) state_next = rwz_pkg::ST_IDLE;
      rwz_pkg::ST_BLANK: if (sts.out_free) state_next = rwz_pkg::ST_IDLE;
      default:           state_next = rwz_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      rwz_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      rwz_pkg::ST_READ:  cmd.rd = 1'b1;
      rwz_pkg::ST_UPD:   cmd.upd = 1'b1;
      rwz_pkg::ST_MUL:   cmd.mul = 1'b1;
      rwz_pkg::ST_NUM:   cmd.div_mean = 1'b1;
      rwz_pkg::ST_MDIV:  cmd.div_var = sts.div_done;
      rwz_pkg::ST_VDIV:  cmd.sqrt_go = sts.div_done;
      rwz_pkg::ST_SQRT:  cmd.div_z = sts.sqrt_done;
      rwz_pkg::ST_OUT:   cmd.load_res = sts.out_free;
      rwz_pkg::ST_BLANK: cmd.load_blank = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/rwz_dp.sv */
// Datapath: sample ring, running sums, shared divider and root unit,
// result register. Depends on rwz_pkg, rwz_div and rwz_sqrt.
`default_nettype none

module rwz_dp #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rwz_pkg::cmd_t                     cmd,
  output rwz_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [rwz_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rwz_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic                              new_series,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              last_of_run,
  output logic [rwz_pkg::ZS_W-1:0]          zscore,
  output logic [rwz_pkg::MEAN_W-1:0]        window_mean,
  output logic [rwz_pkg::SD_OUT_W-1:0]      window_stddev,
  output logic                              result_valid,
  output logic                              zero_spread
);

  localparam int S     = SAMPLE_BITS;
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = S + PTR_W;
  localparam int SQ_W  = 2 * S - 1 + PTR_W;
  localparam int NUM_W = SQ_W + WIN_W;
  localparam int SD_W  = S + 8;
  localparam int VAR_W = 2 * SD_W;
  localparam int MQM_W = S + 8;
  localparam int MQ_W  = S + 9;
  localparam int DF_W  = S + 10;
  localparam int DIV_N = NUM_W + 16;
  localparam int DIV_D = (SD_W > 2 * WIN_W) ? SD_W : 2 * WIN_W;

  // configuration
  logic [rwz_pkg::CFG_DATA_W-1:0] wl;
  logic                           bf;
  logic [WIN_W-1:0]               w;

  always_comb begin
    if (wl == '0) begin
      w = WIN_W'(1);
    end else if (wl > rwz_pkg::CFG_DATA_W'(MAX_WINDOW)) begin
      w = WIN_W'(MAX_WINDOW);
    end else begin
      w = WIN_W'(wl);
    end
  end

  // window state
  logic signed [S-1:0]     ring [MAX_WINDOW];
  logic signed [S-1:0]     rd_data;
  logic signed [S-1:0]     x_r;
  logic                    ns_r;
  logic [SQ_W-1:0]         xsq;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sq;
  logic [WIN_W-1:0]        fill;
  logic [PTR_W-1:0]        ptr;
  logic                    ww;

  logic [PTR_W-1:0]        p_fix;
  logic                    warm;
  logic signed [S-1:0]     old;
  logic signed [2*S-1:0]   x_sq_full;
  logic signed [2*S-1:0]   old_sq_full;
  logic [WIN_W-1:0]        ptr_inc;

  assign x_sq_full   = sample * sample;
  assign old_sq_full = old * old;
  assign p_fix   = (ns_r || (WIN_W'(ptr) >= w)) ? '0 : ptr;
  assign warm    = fill < w;
  assign old     = warm ? '0 : rd_data;
  assign ptr_inc = WIN_W'(ptr) + WIN_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_data <= ring[p_fix];
    if (cmd.upd) ring[ptr] <= x_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_r  <= sample;
      ns_r <= new_series;
      xsq  <= SQ_W'($unsigned(x_sq_full));
    end
    if (cmd.upd) ww <= warm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wl   <= rwz_pkg::WINDOW_RESET;
      bf   <= 1'b0;
      sum  <= '0;
      sq   <= '0;
      fill <= '0;
      ptr  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rwz_pkg::REG_WINDOW) begin
        wl   <= cfg_data;
        sum  <= '0;
        sq   <= '0;
        fill <= '0;
        ptr  <= '0;
      end else if (cfg_index == rwz_pkg::REG_BACKFILL) begin
        bf <= cfg_data[0];
      end
    end else if (cmd.rd) begin
      ptr <= p_fix;
      if (ns_r) begin
        sum  <= '0;
        sq   <= '0;
        fill <= '0;
      end
    end else if (cmd.upd) begin
      sum <= sum + SUM_W'(x_r) - SUM_W'(old);
      sq  <= sq + xsq - SQ_W'($unsigned(old_sq_full));
      ptr <= (ptr_inc >= w) ? '0 : PTR_W'(ptr_inc);
      if (warm) fill <= fill + WIN_W'(1);
    end
  end

  // statistics
  logic [NUM_W-1:0]          p1;
  logic [NUM_W-1:0]          p2;
  logic [NUM_W-1:0]          num;
  logic [2*WIN_W-1:0]        w2;
  logic signed [2*SUM_W-1:0] sum_sq_full;
  logic [SUM_W-1:0]          sum_mag;
  logic signed [MQ_W-1:0]    mq;
  logic [MQM_W-1:0]          mq_mag;
  logic signed [DF_W-1:0]    diff;
  logic [DF_W-1:0]           diff_mag;
  logic                      diff_neg;

  logic             div_start;
  logic [DIV_N-1:0] div_a;
  logic [DIV_D-1:0] div_b;
  logic             div_done;
  logic [DIV_N-1:0] div_q;
  logic             sqrt_done;
  logic [SD_W-1:0]  root;

  assign sum_sq_full = sum * sum;
  assign sum_mag  = sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
  assign mq_mag   = MQM_W'(div_q);
  assign diff     = (DF_W'(x_r) <<< 8) - DF_W'(mq);
  assign diff_mag = diff[DF_W-1] ? $unsigned(-diff) : $unsigned(diff);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p1 <= NUM_W'(sq) * NUM_W'(w);
      p2 <= NUM_W'($unsigned(sum_sq_full));
      w2 <= (2 * WIN_W)'(w) * (2 * WIN_W)'(w);
    end
    if (cmd.div_mean) num <= p1 - p2;
    if (cmd.div_var) begin
      mq <= sum[SUM_W-1] ? -$signed({1'b0, mq_mag}) : $signed({1'b0, mq_mag});
    end
    if (cmd.div_z) diff_neg <= diff[DF_W-1];
  end

  assign div_start = cmd.div_mean | cmd.div_var | cmd.div_z;

  always_comb begin
    if (cmd.div_mean) begin
      div_a = DIV_N'({sum_mag, 8'b0}) + DIV_N'(w >> 1);
      div_b = DIV_D'(w);
    end else if (cmd.div_var) begin
      div_a = DIV_N'({num, 16'b0});
      div_b = DIV_D'(w2);
    end else begin
      div_a = DIV_N'({diff_mag, 12'b0});
      div_b = DIV_D'(root);
    end
  end

  rwz_div #(
    .N(DIV_N),
    .D(DIV_D)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  rwz_sqrt #(
    .RW(SD_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_go),
    .radicand (VAR_W'(div_q)),
    .done     (sqrt_done),
    .root     (root)
  );

  // result register; cnt holds the copies still to transfer
  logic [WIN_W-1:0]           cnt;
  logic                       zero;
  logic [rwz_pkg::ZS_W-1:0]   z_sat;
  logic signed [63:0]         mq64;
  logic [63:0]                sd64;
  logic [63:0]                q64;
  logic [rwz_pkg::MEAN_W-1:0] mean_sat;
  logic [rwz_pkg::SD_OUT_W-1:0] sd_sat;

  assign zero = num == '0;
  assign mq64 = 64'(mq);
  assign sd64 = 64'(root);
  assign q64  = 64'(div_q);

  always_comb begin
    if (zero) begin
      z_sat = '0;
    end else if (!diff_neg) begin
      z_sat = (q64 > rwz_pkg::Z_POS_MAX) ? rwz_pkg::Z_SAT_POS : rwz_pkg::ZS_W'(div_q);
    end else begin
      z_sat = (q64 > rwz_pkg::Z_NEG_MAX) ? rwz_pkg::Z_SAT_NEG
                                         : rwz_pkg::ZS_W'(-rwz_pkg::ZS_W'(div_q));
    end
    if (mq64 > rwz_pkg::MEAN_MAX) begin
      mean_sat = rwz_pkg::MEAN_W'(rwz_pkg::MEAN_MAX);
    end else if (mq64 < rwz_pkg::MEAN_MIN) begin
      mean_sat = rwz_pkg::MEAN_W'(rwz_pkg::MEAN_MIN);
    end else begin
      mean_sat = rwz_pkg::MEAN_W'(mq64);
    end
    sd_sat = (sd64 > rwz_pkg::SD_MAX) ? rwz_pkg::SD_OUT_W'(rwz_pkg::SD_MAX)
                                      : rwz_pkg::SD_OUT_W'(root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load_res) begin
      cnt <= (ww && bf) ? w : WIN_W'(1);
    end else if (cmd.load_blank) begin
      cnt <= WIN_W'(1);
    end else if (out_valid && out_ready) begin
      cnt <= cnt - WIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      zscore        <= z_sat;
      window_mean   <= mean_sat;
      window_stddev <= zero ? '0 : sd_sat;
      result_valid  <= 1'b1;
      zero_spread   <= zero;
    end else if (cmd.load_blank) begin
      zscore        <= '0;
      window_mean   <= '0;
      window_stddev <= '0;
      result_valid  <= 1'b0;
      zero_spread   <= 1'b0;
    end
  end

  assign out_valid   = cnt != '0;
  assign last_of_run = cnt == WIN_W'(1);

  assign sts.filling   = warm;
  assign sts.backfill  = bf;
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.out_free  = cnt == '0;

endmodule

`default_nettype wire

/* hw/rtl/rwz_chk.sv */
// Port-level checker for rolling_window_znorm, attached by bind below.
// Depends on rwz_pkg.
`default_nettype none

module rwz_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [rwz_pkg::M_DATA_W-1:0] m_tdata,
  input logic [rwz_pkg::M_USER_W-1:0] m_tuser,
  input logic                         m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed under stall");

  // warm-up results are single, blank and not flagged
  a_blank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == '0 && !m_tuser[1])
    else $error("warm-up result malformed");

  // zero spread forces z-score and deviation to zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[15:0] == '0 && m_tdata[62:40] == '0)
    else $error("zero spread with non-zero z-score or deviation");

  // one sample in flight
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second sample taken while busy");

endmodule

bind rolling_window_znorm rwz_chk u_rwz_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
